// ===== rtl/mte_pkg.sv =====
// ---------------------------------------------------------------------------
// mte_pkg
// Shared widths, register indexes and reset values for the multitap echo.
// ---------------------------------------------------------------------------
package mte_pkg;

  // default build parameters
  localparam int HISTORY_DEPTH_DEF = 131072;
  localparam int MAX_TAPS_DEF      = 8;
  localparam int SAMPLE_WIDTH_DEF  = 16;

  // configuration register widths
  localparam int DELAY_W    = 14;
  localparam int TAPS_W     = 4;
  localparam int DAMP_W     = 16;
  localparam int CFG_DATA_W = 16;
  localparam int CFG_IDX_W  = 2;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_DELAY = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_TAPS  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_DAMP  = 2'd2;

  // register reset values
  localparam logic [DELAY_W-1:0] DELAY_RST = 14'd13230;
  localparam logic [TAPS_W-1:0]  TAPS_RST  = 4'd4;
  localparam logic [DAMP_W-1:0]  DAMP_RST  = 16'd32768;

  // fixed point: tap gains are unsigned Q1.16
  localparam int               FRAC_W     = 16;
  localparam int               GAIN_W     = 17;
  localparam int               MUL_B_W    = GAIN_W + 1;
  localparam logic [GAIN_W-1:0] GAIN_ONE  = 17'd65536;
  localparam int               ROUND_HALF = 32768;

  // tap counter, holds up to the largest allowed tap count (15)
  localparam int TAP_CNT_W = 5;

endpackage

// ===== rtl/mte_ram.sv =====
// ---------------------------------------------------------------------------
// mte_ram
// Generic simple dual-port RAM, one write and one registered read port.
// ---------------------------------------------------------------------------
module mte_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== rtl/mte_mul.sv =====
// ---------------------------------------------------------------------------
// mte_mul
// Shared signed multiplier with registered product, used for both the
// sample-times-gain products and the per-tap gain update.
// ---------------------------------------------------------------------------
module mte_mul #(
  parameter int A_W = 17
) (
  input  logic                                  clk,
  input  logic signed [A_W-1:0]                 a,
  input  logic signed [mte_pkg::MUL_B_W-1:0]    b,
  output logic signed [A_W+mte_pkg::MUL_B_W-1:0] p
);

  import mte_pkg::*;

  // one product per cycle
  always_ff @(posedge clk) begin
    p <= (A_W+MUL_B_W)'(a) * (A_W+MUL_B_W)'(b);
  end

endmodule

// ===== rtl/multitap_echo.sv =====
// ---------------------------------------------------------------------------
// multitap_echo
// Feed-forward multitap echo: each output sample is the rounded, saturated
// sum of damped copies of the input spaced delay_samples apart.
// ---------------------------------------------------------------------------
//
//   channel  signals                          beat taken when
//   -------  -------------------------------  ------------------------
//   cfg      cfg_we cfg_index cfg_data        cfg_we high
//   in       in_valid in_stall sample_in      in_valid && !in_stall
//   out      out_valid out_stall sample_out   out_valid && !out_stall
//            clipped
//
// Items are worked one at a time. The delay is first brought below
// HISTORY_DEPTH, one whole multiple at a time; taps is tap_count capped at
// MAX_TAPS. Each tap uses the single shared multiplier twice (sample
// product, then gain update) and the one history read port.
// No history clearing pass: a fill mark makes never-written entries read
// as zero, so the block takes items right after reset.
// in_stall is high during reset and while an item is in work; a finished
// beat waits in the output register, and only the final load waits on
// out_stall.
// ---------------------------------------------------------------------------
module multitap_echo #(
  parameter int HISTORY_DEPTH = mte_pkg::HISTORY_DEPTH_DEF,
  parameter int MAX_TAPS      = mte_pkg::MAX_TAPS_DEF,
  parameter int SAMPLE_WIDTH  = mte_pkg::SAMPLE_WIDTH_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_we,
  input  logic [mte_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [mte_pkg::CFG_DATA_W-1:0]   cfg_data,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic signed [SAMPLE_WIDTH-1:0]   sample_in,
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic signed [SAMPLE_WIDTH-1:0]   sample_out,
  output logic                             clipped
);

  import mte_pkg::*;

  localparam int ADDR_W = $clog2(HISTORY_DEPTH);
  localparam int RED_W  = (ADDR_W + 1 > DELAY_W) ? ADDR_W + 1 : DELAY_W;
  localparam int A_W    = (SAMPLE_WIDTH > GAIN_W) ? SAMPLE_WIDTH : GAIN_W;
  localparam int P_W    = A_W + MUL_B_W;
  localparam int ACC_W  = P_W + TAP_CNT_W;

  localparam logic [RED_W-1:0]     DEPTH_R   = RED_W'(HISTORY_DEPTH);
  localparam logic [ADDR_W:0]      DEPTH_A   = (ADDR_W+1)'(HISTORY_DEPTH);
  localparam logic [ADDR_W-1:0]    LAST_ADDR = ADDR_W'(HISTORY_DEPTH - 1);
  localparam logic [TAP_CNT_W-1:0] TAPS_MAX  = TAP_CNT_W'(MAX_TAPS);
  localparam logic signed [ACC_W-1:0] SMAX   = ACC_W'((1 << (SAMPLE_WIDTH - 1)) - 1);
  localparam logic signed [ACC_W-1:0] SMIN   = -SMAX - ACC_W'(1);
  localparam logic signed [ACC_W-1:0] HALF   = ACC_W'(ROUND_HALF);

  typedef enum logic [2:0] {
    S_IDLE, S_RED, S_WR, S_RD, S_MS, S_MG, S_RND
  } state_t;

  // configuration registers
  logic [DELAY_W-1:0] delay_samples;
  logic [TAPS_W-1:0]  tap_count;
  logic [DAMP_W-1:0]  damp_gain;

  // sequencer state and datapath registers
  state_t                    state;
  logic signed [SAMPLE_WIDTH-1:0] sample_r;
  logic [RED_W-1:0]          dmod;
  logic [ADDR_W-1:0]         wp;
  logic                      wrapped;
  logic [ADDR_W-1:0]         addr;
  logic                      rd_vld;
  logic [TAP_CNT_W-1:0]      tap_idx;
  logic [TAP_CNT_W-1:0]      taps;
  logic [GAIN_W-1:0]         gain;
  logic signed [ACC_W-1:0]   acc;

  // memory and multiplier hookup
  logic                      ram_we;
  logic [SAMPLE_WIDTH-1:0]   ram_rdata;
  logic signed [A_W-1:0]     mul_a;
  logic signed [MUL_B_W-1:0] mul_b;
  logic signed [P_W-1:0]     prod;

  // combinational helpers
  logic [ADDR_W-1:0]         dstep;
  logic [ADDR_W:0]           adiff;
  logic [ADDR_W-1:0]         addr_step;
  logic [2*FRAC_W+1:0]       gsum;
  logic [GAIN_W-1:0]         gain_next;
  logic [TAP_CNT_W-1:0]      tap_idx_next;
  logic signed [ACC_W-1:0]   rsum;
  logic signed [ACC_W-1:0]   rq;
  logic [ADDR_W-1:0]         wp_next;
  logic                      out_load;

  assign in_stall = rst || (state != S_IDLE);
  assign ram_we   = (state == S_WR);

  // result goes into the output register this cycle
  assign out_load = (state == S_RND) && (!out_valid || !out_stall);

  // tap count capped at the build limit
  assign taps = ({1'b0, tap_count} > TAPS_MAX) ? TAPS_MAX : TAP_CNT_W'(tap_count);

  // next tap address, one delay further back, wrapping around the history
  assign dstep     = dmod[ADDR_W-1:0];
  assign adiff     = {1'b0, addr} - {1'b0, dstep};
  assign addr_step = adiff[ADDR_W] ? ADDR_W'(adiff + DEPTH_A) : adiff[ADDR_W-1:0];

  // gain update rounds half up, product is damp * gain < 2^33
  assign gsum      = prod[2*FRAC_W+1:0] + (2*FRAC_W+2)'(ROUND_HALF);
  assign gain_next = gsum[FRAC_W+GAIN_W-1:FRAC_W];

  assign tap_idx_next = tap_idx + TAP_CNT_W'(1);

  // final rounding, floor after adding one half
  assign rsum = acc + HALF;
  assign rq   = rsum >>> FRAC_W;

  assign wp_next = (wp == LAST_ADDR) ? '0 : wp + ADDR_W'(1);

  // multiplier operand select
  always_comb begin
    mul_a = '0;
    mul_b = MUL_B_W'({1'b0, gain});
    unique case (state)
      S_MS: begin
        if (rd_vld) begin
          mul_a = A_W'($signed(ram_rdata));
        end
      end
      S_MG: begin
        mul_a = A_W'({1'b0, damp_gain});
      end
      default: begin
        mul_a = '0;
      end
    endcase
  end

  mte_ram #(
    .WIDTH (SAMPLE_WIDTH),
    .DEPTH (HISTORY_DEPTH)
  ) u_hist (
    .clk   (clk),
    .we    (ram_we),
    .waddr (wp),
    .wdata (sample_r),
    .raddr (addr),
    .rdata (ram_rdata)
  );

  mte_mul #(
    .A_W (A_W)
  ) u_mul (
    .clk (clk),
    .a   (mul_a),
    .b   (mul_b),
    .p   (prod)
  );

  // configuration write port
  always_ff @(posedge clk) begin
    if (rst) begin
      delay_samples <= DELAY_RST;
      tap_count     <= TAPS_RST;
      damp_gain     <= DAMP_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_DELAY: delay_samples <= cfg_data[DELAY_W-1:0];
        REG_TAPS:  tap_count     <= cfg_data[TAPS_W-1:0];
        REG_DAMP:  damp_gain     <= cfg_data[DAMP_W-1:0];
        default:   ;
      endcase
    end
  end

  // sequencer, datapath and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      wp        <= '0;
      wrapped   <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && !out_stall && !out_load) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            sample_r <= sample_in;
            dmod     <= RED_W'(delay_samples);
            state    <= S_RED;
          end
        end
        // bring the delay below the history depth
        S_RED: begin
          if (dmod >= DEPTH_R) begin
            dmod <= dmod - DEPTH_R;
          end else begin
            state <= S_WR;
          end
        end
        // store the new sample, tap 0 reads it back
        S_WR: begin
          addr    <= wp;
          tap_idx <= '0;
          gain    <= GAIN_ONE;
          acc     <= '0;
          state   <= (taps == '0) ? S_RND : S_RD;
        end
        // issue the tap read, fold in the gain from the last update
        S_RD: begin
          rd_vld <= wrapped || (addr <= wp);
          addr   <= addr_step;
          if (tap_idx != '0) begin
            gain <= gain_next;
          end
          state <= S_MS;
        end
        // sample times gain goes into the multiplier
        S_MS: begin
          state <= S_MG;
        end
        // accumulate, gain times damp goes into the multiplier
        S_MG: begin
          acc     <= acc + ACC_W'(prod);
          tap_idx <= tap_idx_next;
          state   <= (tap_idx_next == taps) ? S_RND : S_RD;
        end
        // round, saturate and hand over once the output register is free
        S_RND: begin
          if (out_load) begin
            out_valid <= 1'b1;
            if (rq > SMAX) begin
              sample_out <= SMAX[SAMPLE_WIDTH-1:0];
              clipped    <= 1'b1;
            end else if (rq < SMIN) begin
              sample_out <= SMIN[SAMPLE_WIDTH-1:0];
              clipped    <= 1'b1;
            end else begin
              sample_out <= rq[SAMPLE_WIDTH-1:0];
              clipped    <= 1'b0;
            end
            wp <= wp_next;
            if (wp == LAST_ADDR) begin
              wrapped <= 1'b1;
            end
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

// ===== rtl/mte_chk.sv =====
// ---------------------------------------------------------------------------
// mte_chk
// Port-level checks for the multitap echo, bound to the top level.
// ---------------------------------------------------------------------------
module mte_chk #(
  parameter int SAMPLE_WIDTH = mte_pkg::SAMPLE_WIDTH_DEF
) (
  input logic                           clk,
  input logic                           rst,
  input logic                           in_valid,
  input logic                           in_stall,
  input logic signed [SAMPLE_WIDTH-1:0] sample_in,
  input logic                           out_valid,
  input logic                           out_stall,
  input logic signed [SAMPLE_WIDTH-1:0] sample_out,
  input logic                           clipped
);

  localparam logic signed [SAMPLE_WIDTH-1:0] SMAX = {1'b0, {(SAMPLE_WIDTH-1){1'b1}}};
  localparam logic signed [SAMPLE_WIDTH-1:0] SMIN = {1'b1, {(SAMPLE_WIDTH-1){1'b0}}};

  // no result beat right out of reset
  a_reset_empty: assert property (@(posedge clk) $past(rst) |-> !out_valid)
    else $error("out_valid set right after reset");

  // an accepted beat keeps the block busy on the next cycle
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> in_stall)
    else $error("input taken on back-to-back cycles");

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(sample_out) && $stable(clipped))
    else $error("stalled result beat changed");

  // a clipped result sits on a rail
  a_clip_rail: assert property (@(posedge clk) disable iff (rst)
    out_valid && clipped |-> (sample_out == SMAX) || (sample_out == SMIN))
    else $error("clipped result not at full scale");

  // a stalled input beat holds
  a_in_hold: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_stall |=> in_valid && $stable(sample_in))
    else $error("stalled input beat changed");

endmodule

bind multitap_echo mte_chk #(.SAMPLE_WIDTH(SAMPLE_WIDTH)) u_mte_chk (
  .clk        (clk),
  .rst        (rst),
  .in_valid   (in_valid),
  .in_stall   (in_stall),
  .sample_in  (sample_in),
  .out_valid  (out_valid),
  .out_stall  (out_stall),
  .sample_out (sample_out),
  .clipped    (clipped)
);
